[rtl/mcfc_pkg.sv]
// types and constants shared by the fracture check block
package mcfc_pkg;

    localparam int COEF_FRAC = 16;
    localparam logic [16:0] COEF_ONE = 17'd65536;

    localparam logic [2:0] REG_COHESION = 3'd0;
    localparam logic [2:0] REG_TENSILE  = 3'd1;
    localparam logic [2:0] REG_TAN_PHI  = 3'd2;
    localparam logic [2:0] REG_SIN_PHI  = 3'd3;
    localparam logic [2:0] REG_COS_PHI  = 3'd4;
    localparam logic [2:0] REG_WEIGHT   = 3'd5;

    localparam logic [1:0] CLS_INTACT  = 2'd0;
    localparam logic [1:0] CLS_TENSILE = 2'd1;
    localparam logic [1:0] CLS_SHEAR   = 2'd2;

    typedef struct packed {
        logic               req_type;
        logic               unbreakable_i;
        logic               unbreakable_j;
        logic               bond_connected_in;
        logic [1:0]         fail_cls_i;
        logic [1:0]         fail_cls_j;
        logic signed [31:0] sxx_i;
        logic signed [31:0] syy_i;
        logic signed [31:0] sxy_i;
        logic signed [31:0] sxx_j;
        logic signed [31:0] syy_j;
        logic signed [31:0] sxy_j;
    } in_item_t;

    typedef struct packed {
        logic [1:0] point_failure;
        logic       bond_connected_out;
    } out_item_t;

    typedef struct packed {
        logic req_type;
        logic conn;
        logic ub_i;
        logic skip;
        logic cut;
    } ctl_t;

    typedef struct packed {
        ctl_t               ctl;
        logic signed [32:0] dsum;
    } sqrt_tag_t;

endpackage

[rtl/mcfc_ifs.sv]
// valid/ready channel interfaces for items and configuration writes
interface mcfc_in_if;
    logic              valid;
    logic              ready;
    mcfc_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mcfc_out_if;
    logic               valid;
    logic               ready;
    mcfc_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mcfc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/mohr_coulomb_fracture_check.sv]
// top level of the plane stress mohr-coulomb fracture check
// Takes one item per clock unless stalled and returns one result per item, in order.
// There are 41 register stages: five capture the item, blend the two point stresses,
// form the difference terms, square them and sum them; 33 stages then take the
// square root one result bit each; three stages form shear and normal stress,
// the friction term and the final decision. A stall on the output freezes the
// whole pipeline, so input ready follows output ready while a result is waiting.
// Configuration writes are always taken; later stages read the registers directly,
// so write them only while no item is in flight.
module mohr_coulomb_fracture_check (
    input  logic       clk,
    input  logic       rst_n,
    mcfc_in_if.sink    in_item,
    mcfc_out_if.source out_item,
    mcfc_cfg_if.sink   cfg
);
    import mcfc_pkg::*;

    logic [30:0] cohesion_reg;
    logic [30:0] tensile_reg;
    logic [23:0] tan_reg;
    logic [16:0] sin_reg;
    logic [16:0] cos_reg;
    logic [16:0] weight_reg;

    logic en;

    // config registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cohesion_reg <= '0;
            tensile_reg  <= '0;
            tan_reg      <= '0;
            sin_reg      <= '0;
            cos_reg      <= COEF_ONE;
            weight_reg   <= 17'd62259;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_COHESION: cohesion_reg <= cfg.data[30:0];
                REG_TENSILE:  tensile_reg  <= cfg.data[30:0];
                REG_TAN_PHI:  tan_reg      <= cfg.data[23:0];
                REG_SIN_PHI:  sin_reg      <= cfg.data[16:0];
                REG_COS_PHI:  cos_reg      <= cfg.data[16:0];
                REG_WEIGHT:   weight_reg   <= cfg.data[16:0];
                default:      ;
            endcase
        end
    end

    // stage 0: capture and bond decisions
    logic        s0_vld_reg;
    ctl_t        s0_ctl_reg, s0_ctl_next;
    logic [16:0] s0_wi_reg, s0_wi_next, s0_wj_reg, s0_wj_next;
    in_item_t    s0_item_reg;
    logic [16:0] wm;

    always_comb
    begin
        wm = (weight_reg > COEF_ONE) ? COEF_ONE : weight_reg;
        s0_ctl_next.req_type = in_item.data.req_type;
        s0_ctl_next.conn     = in_item.data.bond_connected_in;
        s0_ctl_next.ub_i     = in_item.data.unbreakable_i;
        s0_ctl_next.skip     = in_item.data.unbreakable_i | in_item.data.unbreakable_j
                               | !in_item.data.bond_connected_in
                               | (in_item.data.fail_cls_i == CLS_INTACT
                                  && in_item.data.fail_cls_j == CLS_INTACT);
        s0_ctl_next.cut      = (in_item.data.fail_cls_i == in_item.data.fail_cls_j);
        if (!in_item.data.req_type)
        begin
            s0_wi_next = COEF_ONE;
            s0_wj_next = '0;
        end
        else if (in_item.data.fail_cls_i > in_item.data.fail_cls_j)
        begin
            s0_wi_next = wm;
            s0_wj_next = COEF_ONE - wm;
        end
        else
        begin
            s0_wi_next = COEF_ONE - wm;
            s0_wj_next = wm;
        end
    end

    // stage 1: blend
    logic               s1_vld_reg;
    ctl_t               s1_ctl_reg;
    logic signed [31:0] s1_sx_reg, s1_sy_reg, s1_sxy_reg;
    logic signed [50:0] bl_xx, bl_yy, bl_xy;
    logic signed [17:0] wi_s, wj_s;

    assign wi_s  = $signed({1'b0, s0_wi_reg});
    assign wj_s  = $signed({1'b0, s0_wj_reg});
    assign bl_xx = 51'(wi_s * s0_item_reg.sxx_i) + 51'(wj_s * s0_item_reg.sxx_j);
    assign bl_yy = 51'(wi_s * s0_item_reg.syy_i) + 51'(wj_s * s0_item_reg.syy_j);
    assign bl_xy = 51'(wi_s * s0_item_reg.sxy_i) + 51'(wj_s * s0_item_reg.sxy_j);

    // stage 2: difference terms
    logic               s2_vld_reg;
    ctl_t               s2_ctl_reg;
    logic [32:0]        s2_ad_reg, s2_e_reg;
    logic signed [32:0] s2_dsum_reg;
    logic signed [32:0] dif;
    logic [31:0]        abs_xy;

    assign dif    = 33'(s1_sx_reg) - 33'(s1_sy_reg);
    assign abs_xy = s1_sxy_reg[31] ? 32'(-s1_sxy_reg) : 32'(s1_sxy_reg);

    // stage 3: squares, stage 4: radicand
    logic               s3_vld_reg, s4_vld_reg;
    ctl_t               s3_ctl_reg;
    logic signed [32:0] s3_dsum_reg;
    logic [65:0]        s3_sqa_reg, s3_sqe_reg;
    logic [65:0]        s4_rad_reg;
    sqrt_tag_t          s4_tag_reg;

    // square root
    logic        rt_vld;
    logic [33:0] rt_root;
    sqrt_tag_t   rt_tag;

    mcfc_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_vld_reg),
        .in_rad    (s4_rad_reg),
        .in_tag    (s4_tag_reg),
        .out_valid (rt_vld),
        .out_root  (rt_root),
        .out_tag   (rt_tag)
    );

    // m1: shear, normal and major principal
    logic               m1_vld_reg;
    ctl_t               m1_ctl_reg;
    logic [34:0]        m1_shear_reg;
    logic signed [36:0] m1_normal_reg;
    logic signed [35:0] m1_p2_reg;
    logic [50:0]        prod_c, prod_s;

    assign prod_c = 51'(rt_root) * 51'(cos_reg);
    assign prod_s = 51'(rt_root) * 51'(sin_reg);

    // m2: friction term
    logic               m2_vld_reg;
    ctl_t               m2_ctl_reg;
    logic [34:0]        m2_shear_reg;
    logic signed [45:0] m2_fric_reg;
    logic               m2_neg_reg, m2_pos_reg, m2_tens_reg;
    logic signed [61:0] prod_f;

    assign prod_f = 62'($signed({1'b0, tan_reg}) * m1_normal_reg);

    // output stage
    logic               out_vld_reg;
    out_item_t          out_data_reg, out_data_next;
    logic signed [46:0] lim;
    logic [46:0]        abs_lim;
    logic               shear_fail;
    logic [1:0]         cls;

    always_comb
    begin
        lim        = 47'($signed({1'b0, cohesion_reg, 1'b0})) - 47'(m2_fric_reg);
        abs_lim    = lim[46] ? 47'(-lim) : 47'(lim);
        shear_fail = (47'(m2_shear_reg) >= abs_lim) && m2_neg_reg;
        if (shear_fail)
            cls = CLS_SHEAR;
        else if (m2_tens_reg && (!m2_ctl_reg.req_type || m2_pos_reg))
            cls = CLS_TENSILE;
        else
            cls = CLS_INTACT;
        out_data_next.point_failure      = CLS_INTACT;
        out_data_next.bond_connected_out = m2_ctl_reg.conn;
        if (!m2_ctl_reg.req_type)
        begin
            if (!m2_ctl_reg.ub_i)
                out_data_next.point_failure = cls;
        end
        else if (!m2_ctl_reg.skip)
        begin
            if (m2_ctl_reg.cut || cls != CLS_INTACT)
                out_data_next.bond_connected_out = 1'b0;
        end
    end

    assign en             = !out_vld_reg || out_item.ready;
    assign in_item.ready  = en;
    assign out_item.valid = out_vld_reg;
    assign out_item.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg  <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            m1_vld_reg  <= 1'b0;
            m2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg  <= in_item.valid;
            s1_vld_reg  <= s0_vld_reg;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            m1_vld_reg  <= rt_vld;
            m2_vld_reg  <= m1_vld_reg;
            out_vld_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_ctl_reg    <= s0_ctl_next;
            s0_wi_reg     <= s0_wi_next;
            s0_wj_reg     <= s0_wj_next;
            s0_item_reg   <= in_item.data;
            s1_ctl_reg    <= s0_ctl_reg;
            s1_sx_reg     <= bl_xx[47:16];
            s1_sy_reg     <= bl_yy[47:16];
            s1_sxy_reg    <= bl_xy[47:16];
            s2_ctl_reg    <= s1_ctl_reg;
            s2_ad_reg     <= dif[32] ? 33'(-dif) : 33'(dif);
            s2_e_reg      <= {abs_xy, 1'b0};
            s2_dsum_reg   <= 33'(s1_sx_reg) + 33'(s1_sy_reg);
            s3_ctl_reg    <= s2_ctl_reg;
            s3_dsum_reg   <= s2_dsum_reg;
            s3_sqa_reg    <= 66'(s2_ad_reg) * 66'(s2_ad_reg);
            s3_sqe_reg    <= 66'(s2_e_reg) * 66'(s2_e_reg);
            s4_rad_reg    <= s3_sqa_reg + s3_sqe_reg;
            s4_tag_reg    <= '{ctl: s3_ctl_reg, dsum: s3_dsum_reg};
            m1_ctl_reg    <= rt_tag.ctl;
            m1_shear_reg  <= prod_c[50:16];
            m1_normal_reg <= 37'(rt_tag.dsum) + $signed({2'b00, prod_s[50:16]});
            m1_p2_reg     <= 36'(rt_tag.dsum) + $signed({2'b00, rt_root});
            m2_ctl_reg    <= m1_ctl_reg;
            m2_shear_reg  <= m1_shear_reg;
            m2_fric_reg   <= prod_f[61:16];
            m2_neg_reg    <= m1_normal_reg[36];
            m2_pos_reg    <= !m1_normal_reg[36] && (m1_normal_reg != '0);
            m2_tens_reg   <= m1_p2_reg >= $signed({4'b0000, tensile_reg, 1'b0});
            out_data_reg  <= out_data_next;
        end
    end

endmodule

[rtl/mcfc_isqrt.sv]
// pipelined truncated square root, one result bit per stage
module mcfc_isqrt (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [65:0]           in_rad,
    input  mcfc_pkg::sqrt_tag_t   in_tag,
    output logic                  out_valid,
    output logic [33:0]           out_root,
    output mcfc_pkg::sqrt_tag_t   out_tag
);
    import mcfc_pkg::*;

    localparam int NSTEP = 33;

    logic [NSTEP-1:0] vld_reg;
    logic [65:0]      rad_reg  [NSTEP];
    logic [36:0]      rem_reg  [NSTEP];
    logic [33:0]      root_reg [NSTEP];
    sqrt_tag_t        tag_reg  [NSTEP];

    for (genvar s = 0; s < NSTEP; s++)
    begin : g_step
        localparam int K = NSTEP - 1 - s;
        logic        v_prev;
        logic [65:0] rad_prev;
        logic [36:0] rem_prev;
        logic [33:0] root_prev;
        sqrt_tag_t   tag_prev;
        logic [36:0] rem_sh;
        logic [36:0] trial;
        logic [36:0] rem_next;
        logic [33:0] root_next;

        if (s == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign rad_prev  = in_rad;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign tag_prev  = in_tag;
        end
        else
        begin : g_rest
            assign v_prev    = vld_reg[s-1];
            assign rad_prev  = rad_reg[s-1];
            assign rem_prev  = rem_reg[s-1];
            assign root_prev = root_reg[s-1];
            assign tag_prev  = tag_reg[s-1];
        end

        always_comb
        begin
            rem_sh = {rem_prev[34:0], rad_prev[2*K+1 -: 2]};
            trial  = {1'b0, root_prev, 2'b01};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_prev[32:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_prev[32:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[s]  <= rad_prev;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
                tag_reg[s]  <= tag_prev;
            end
        end
    end

    assign out_valid = vld_reg[NSTEP-1];
    assign out_root  = root_reg[NSTEP-1];
    assign out_tag   = tag_reg[NSTEP-1];

endmodule

[rtl/mcfc_checker.sv]
// port checks for the fracture check block and their binding
module mcfc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] point_failure,
    input logic       bond_out,
    input logic       cfg_valid,
    input logic       cfg_ready
);
    import mcfc_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(point_failure) && $stable(bond_out))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    a_class_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> point_failure == CLS_INTACT || point_failure == CLS_TENSILE
                      || point_failure == CLS_SHEAR)
        else $error("illegal failure class");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind mohr_coulomb_fracture_check mcfc_checker u_mcfc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_item.valid),
    .in_ready      (in_item.ready),
    .out_valid     (out_item.valid),
    .out_ready     (out_item.ready),
    .point_failure (out_item.data.point_failure),
    .bond_out      (out_item.data.bond_connected_out),
    .cfg_valid     (cfg.valid),
    .cfg_ready     (cfg.ready)
);
